// ===== rtl/isv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isv_pkg
// Shared types, character codes and small modulo helpers for the ISBN
// stream validator.
// ----------------------------------------------------------------------------
package isv_pkg;

  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [3:0] COUNT_SAT = 4'd14;
  localparam logic [3:0] LEN_TEN   = 4'd10;
  localparam logic [3:0] LEN_THIRT = 4'd13;
  localparam logic [3:0] POS_CHECK = 4'd9;

  typedef enum logic [2:0] {
    ISV_ERR_OK     = 3'd0,
    ISV_ERR_EMPTY  = 3'd1,
    ISV_ERR_EDGE   = 3'd2,
    ISV_ERR_DOUBLE = 3'd3,
    ISV_ERR_LEN    = 3'd4,
    ISV_ERR_BAD10  = 3'd5,
    ISV_ERR_BAD13  = 3'd6
  } isv_err_e;

  typedef struct packed {
    logic     valid_res;
    isv_err_e error_code;
  } isv_res_t;

  // x mod 11 for x below 128, reciprocal 187/2048 is exact over that range
  function automatic logic [3:0] mod11_7b(input logic [6:0] x);
    logic [14:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    p = {8'd0, x} * 15'd187;
    q = p[14:11];
    r = x - ({3'd0, q} * 7'd11);
    return r[3:0];
  endfunction

  // x mod 10 for x below 64, reciprocal 205/2048 is exact over that range
  function automatic logic [3:0] mod10_6b(input logic [5:0] x);
    logic [13:0] p;
    logic [2:0]  q;
    logic [5:0]  r;
    p = {8'd0, x} * 14'd205;
    q = p[13:11];
    r = x - ({3'd0, q} * 6'd10);
    return r[3:0];
  endfunction

endpackage

// ===== rtl/isv_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isv_accum
// Running checksum and format state, updated once per character, with the
// verdict formed on the final transaction of a string.
// ----------------------------------------------------------------------------
module isv_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        char_code_i,
  input  logic              last_i,
  input  logic              no_char_i,
  output isv_pkg::isv_res_t res_o
);
  import isv_pkg::*;

  logic [3:0] cnt_q, cnt_d, cnt_n;
  logic [3:0] s11_q, s11_d, s11_n;
  logic [3:0] s10_q, s10_d, s10_n;
  logic       prev_q, prev_d, prev_n;
  logic       seen_q, seen_d, seen_n;
  logic       start_q, start_d, start_n;
  logic       dbl_q, dbl_d, dbl_n;
  logic       bad10_q, bad10_d, bad10_n;
  logic       bad13_q, bad13_d, bad13_n;

  logic       take;
  logic       hyph;
  logic       dig;
  logic       ok10;
  logic [3:0] val10;
  logic [3:0] wgt11;
  logic [6:0] sum11;
  logic [5:0] sum10;
  isv_err_e   code;

  assign take  = step_i && !no_char_i;
  assign hyph  = (char_code_i == CH_HYPHEN);
  assign dig   = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign ok10  = dig || ((cnt_q == POS_CHECK) && (char_code_i == CH_X));
  assign val10 = dig ? char_code_i[3:0] : 4'd10;
  assign wgt11 = cnt_q + 4'd1;
  assign sum11 = {3'd0, s11_q} + ({3'd0, wgt11} * {3'd0, val10});
  assign sum10 = {2'd0, s10_q} + {2'd0, char_code_i[3:0]}
               + (cnt_q[0] ? {1'b0, char_code_i[3:0], 1'b0} : 6'd0);

  always_comb begin
    cnt_n   = cnt_q;
    s11_n   = s11_q;
    s10_n   = s10_q;
    prev_n  = prev_q;
    seen_n  = seen_q;
    start_n = start_q;
    dbl_n   = dbl_q;
    bad10_n = bad10_q;
    bad13_n = bad13_q;
    if (take) begin
      start_n = start_q | (!seen_q & hyph);
      dbl_n   = dbl_q | (hyph & prev_q);
      seen_n  = 1'b1;
      prev_n  = hyph;
      if (!hyph) begin
        if (cnt_q < LEN_TEN) begin
          bad10_n = bad10_q | !ok10;
          s11_n   = mod11_7b(sum11);
        end
        if (cnt_q < LEN_THIRT) begin
          if (!dig) begin
            bad13_n = 1'b1;
          end else begin
            s10_n = mod10_6b(sum10);
          end
        end
        if (cnt_q < COUNT_SAT) begin
          cnt_n = cnt_q + 4'd1;
        end
      end
    end
  end

  always_comb begin
    if (!seen_n) begin
      code = ISV_ERR_EMPTY;
    end else if (start_n || prev_n) begin
      code = ISV_ERR_EDGE;
    end else if (dbl_n) begin
      code = ISV_ERR_DOUBLE;
    end else if (cnt_n == LEN_TEN) begin
      code = (bad10_n || (s11_n != 4'd0)) ? ISV_ERR_BAD10 : ISV_ERR_OK;
    end else if (cnt_n == LEN_THIRT) begin
      code = (bad13_n || (s10_n != 4'd0)) ? ISV_ERR_BAD13 : ISV_ERR_OK;
    end else begin
      code = ISV_ERR_LEN;
    end
    res_o.error_code = code;
    res_o.valid_res  = (code == ISV_ERR_OK);
  end

  always_comb begin
    cnt_d   = cnt_q;
    s11_d   = s11_q;
    s10_d   = s10_q;
    prev_d  = prev_q;
    seen_d  = seen_q;
    start_d = start_q;
    dbl_d   = dbl_q;
    bad10_d = bad10_q;
    bad13_d = bad13_q;
    if (step_i) begin
      if (last_i) begin
        cnt_d   = '0;
        s11_d   = '0;
        s10_d   = '0;
        prev_d  = 1'b0;
        seen_d  = 1'b0;
        start_d = 1'b0;
        dbl_d   = 1'b0;
        bad10_d = 1'b0;
        bad13_d = 1'b0;
      end else begin
        cnt_d   = cnt_n;
        s11_d   = s11_n;
        s10_d   = s10_n;
        prev_d  = prev_n;
        seen_d  = seen_n;
        start_d = start_n;
        dbl_d   = dbl_n;
        bad10_d = bad10_n;
        bad13_d = bad13_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      s11_q   <= '0;
      s10_q   <= '0;
      prev_q  <= 1'b0;
      seen_q  <= 1'b0;
      start_q <= 1'b0;
      dbl_q   <= 1'b0;
      bad10_q <= 1'b0;
      bad13_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      s11_q   <= s11_d;
      s10_q   <= s10_d;
      prev_q  <= prev_d;
      seen_q  <= seen_d;
      start_q <= start_d;
      dbl_q   <= dbl_d;
      bad10_q <= bad10_d;
      bad13_q <= bad13_d;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> (cnt_q == 4'd0) && !seen_q && !prev_q)
    else $error("state not cleared after final transaction");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= COUNT_SAT)
    else $error("character count beyond saturation");

  a_seen_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (cnt_q == 4'd0) && !dbl_q && !start_q)
    else $error("flags set with no character seen");

endmodule

// ===== rtl/isv_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isv_out_reg
// Result register holding one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module isv_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  isv_pkg::isv_res_t res_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              valid_res_o,
  output logic [2:0]        error_code_o
);
  import isv_pkg::*;

  logic     vld_q, vld_d;
  isv_res_t res_q;

  assign space_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o  = vld_q;
  assign valid_res_o  = res_q.valid_res;
  assign error_code_o = res_q.error_code;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> space_o)
    else $error("result register overwritten before transaction");

  a_res_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (res_q.valid_res == (res_q.error_code == ISV_ERR_OK)))
    else $error("valid_res disagrees with error code");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> vld_q)
    else $error("loaded result not presented");

endmodule

// ===== rtl/isbn_stream_validator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isbn_stream_validator_top
// Streaming ISBN-10/13 validator, one character per transaction, one verdict
// per string.
// ----------------------------------------------------------------------------
// the verdict is formed from the input register and running state, then held in the result register
// throughput: one character per cycle outside the stall below, set by the input
//   register feeding the running checksum state directly
// input stalls only while a final character waits on a full result register
// reset clears the input register valid, running state and result register valid
module isbn_stream_validator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       last_i,
  input  logic       no_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o,
  output logic [2:0] error_code_o
);
  import isv_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] char_q;
  logic       last_q;
  logic       none_q;
  logic       accept;
  logic       step;
  logic       space;
  isv_res_t   res;

  assign step       = in_vld_q && (!last_q || space);
  assign in_ready_o = !in_vld_q || step;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_code_i;
      last_q <= last_i;
      none_q <= no_char_i;
    end
  end

  isv_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_code_i (char_q),
    .last_i      (last_q),
    .no_char_i   (none_q),
    .res_o       (res)
  );

  isv_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step && last_q),
    .res_i        (res),
    .space_o      (space),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .valid_res_o  (valid_res_o),
    .error_code_o (error_code_o)
  );

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && last_q && out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked final transaction");

  a_final_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && last_q |=> out_valid_o)
    else $error("final transaction gave no result");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !step |=> in_vld_q && $stable(char_q) && $stable(last_q))
    else $error("held transaction lost or changed");

endmodule
